// ----- sv/molecule_pool_exp_euler_step_assert.svh -----
// assertion macros used by the checker file
`ifndef MOLECULE_POOL_EXP_EULER_STEP_ASSERT_SVH
`define MOLECULE_POOL_EXP_EULER_STEP_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define MPE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define MPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define MPE_ASSERT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mpe_pkg.sv -----
package mpe_pkg;

  // value formats
  localparam int VALUE_W = 48;
  localparam int DT_W = 32;
  localparam int CMD_W = 3;
  localparam int PROD_W = 2 * VALUE_W;
  localparam int CFG_IDX_W = 1;

  // exponential step
  localparam int RED_W = 37;
  localparam int TERM_W = 33;
  localparam int SUM_W = 34;
  localparam int SHIFT_W = 6;
  localparam int IDX_W = 4;
  localparam int TAYLOR_TERMS = 14;
  localparam logic [RED_W-1:0] LN2_Q32 = 37'd2977044472;
  localparam logic [RED_W-1:0] X_LIMIT = RED_W'(64'd33 * 64'd2977044472);
  localparam logic [TERM_W-1:0] ONE_TERM = {1'b1, {DT_W{1'b0}}};
  localparam logic [SUM_W-1:0] ONE_SUM = {2'b01, {DT_W{1'b0}}};

  // serial arithmetic unit
  localparam int ARITH_CNT_W = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [DT_W-1:0] TIME_STEP_RESET = 32'd42949673;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_INC    = 3'd1,
    CMD_DEC    = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_REINIT = 3'd4,
    CMD_SET    = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP     = 1'b0,
    REG_INITIAL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_TICK,
    OP_REINIT,
    OP_SET
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [VALUE_W-1:0] amt_a;
    logic [VALUE_W-1:0] amt_b;
  } q_entry_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic [PROD_W-1:0] opa;
    logic [VALUE_W-1:0] opb;
  } arith_req_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_BT,
    B_DIV_X,
    B_RED,
    B_T_MUL,
    B_T_DIV,
    B_MUL_P1,
    B_MUL_T,
    B_MUL_AT,
    B_DIV_P2,
    B_MUL_EU,
    B_EMIT
  } back_state_t;

  function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_W] ? {VALUE_W{1'b1}} : s[VALUE_W-1:0];
  endfunction

endpackage

// ----- sv/mpe_in_if.sv -----
interface mpe_in_if import mpe_pkg::*;;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [VALUE_W-1:0] gain_amount;
  logic [VALUE_W-1:0] loss_amount;
  logic signed [VALUE_W-1:0] signed_amount;
  logic [VALUE_W-1:0] new_count;

  modport source (output valid, command, gain_amount, loss_amount, signed_amount,
                  new_count, input ready);
  modport sink (input valid, command, gain_amount, loss_amount, signed_amount,
                new_count, output ready);
endinterface

// ----- sv/mpe_out_if.sv -----
interface mpe_out_if import mpe_pkg::*;;
  logic valid;
  logic ready;
  logic [VALUE_W-1:0] count;
  logic clamped;

  modport source (output valid, count, clamped, input ready);
  modport sink (input valid, count, clamped, output ready);
endinterface

// ----- sv/mpe_front.sv -----
module mpe_front import mpe_pkg::*; (
  mpe_in_if.sink in_ch,
  input  logic full,
  output logic push,
  output q_entry_t entry
);

  logic neg;
  logic [VALUE_W-1:0] mag;

  // magnitude of the signed amount
  assign neg = in_ch.signed_amount[VALUE_W-1];
  assign mag = neg ? (~in_ch.signed_amount + VALUE_W'(1)) : in_ch.signed_amount;

  assign in_ch.ready = !full;

  // classify the transaction into one queue entry
  always_comb begin
    push = in_ch.valid && !full;
    entry.kind = OP_ACC;
    entry.amt_a = '0;
    entry.amt_b = '0;
    case (cmd_t'(in_ch.command))
      CMD_ADD: begin
        entry.amt_a = in_ch.gain_amount;
        entry.amt_b = in_ch.loss_amount;
      end
      CMD_INC: begin
        if (neg) entry.amt_b = mag;
        else entry.amt_a = mag;
      end
      CMD_DEC: begin
        if (neg) entry.amt_a = mag;
        else entry.amt_b = mag;
      end
      CMD_TICK: entry.kind = OP_TICK;
      CMD_REINIT: entry.kind = OP_REINIT;
      CMD_SET: begin
        entry.kind = OP_SET;
        entry.amt_a = in_ch.new_count;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

// ----- sv/mpe_queue.sv -----
module mpe_queue import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  q_entry_t entry_in,
  output logic full,
  input  logic pop,
  output q_entry_t entry_out,
  output logic empty
);

  q_entry_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0] fill;

  assign full = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign entry_out = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop) rptr <= rptr + QPTR_W'(1);
      if (push && !pop) fill <= fill + (QPTR_W+1)'(1);
      else if (pop && !push) fill <= fill - (QPTR_W+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= entry_in;
  end

endmodule

// ----- sv/mpe_arith.sv -----
module mpe_arith import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  arith_req_t req,
  output logic done,
  output logic [PROD_W-1:0] result
);

  logic busy;
  logic is_div;
  logic [ARITH_CNT_W-1:0] cnt;
  logic [PROD_W-1:0] acc;
  logic [VALUE_W-1:0] ma;
  logic [VALUE_W-1:0] mb;
  logic [VALUE_W:0] rem;
  logic [PROD_W-1:0] acc_next;
  logic [VALUE_W:0] rem_next;
  logic [VALUE_W:0] rem_sh;

  assign result = acc;

  // one shift-add or one restoring-divide step
  always_comb begin
    rem_sh = {rem[VALUE_W-1:0], acc[PROD_W-1]};
    rem_next = rem;
    if (is_div) begin
      if (rem_sh >= {1'b0, ma}) begin
        rem_next = rem_sh - {1'b0, ma};
        acc_next = {acc[PROD_W-2:0], 1'b1};
      end else begin
        rem_next = rem_sh;
        acc_next = {acc[PROD_W-2:0], 1'b0};
      end
    end else begin
      acc_next = {acc[PROD_W-2:0], 1'b0} + (mb[VALUE_W-1] ? PROD_W'(ma) : '0);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.is_div ? ARITH_CNT_W'(PROD_W) : ARITH_CNT_W'(VALUE_W);
      end else if (busy) begin
        cnt <= cnt - ARITH_CNT_W'(1);
        if (cnt == ARITH_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc <= req.is_div ? req.opa : '0;
      ma <= req.is_div ? req.opb : req.opa[VALUE_W-1:0];
      mb <= req.opb;
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
      mb <= {mb[VALUE_W-2:0], 1'b0};
    end
  end

endmodule

// ----- sv/mpe_back.sv -----
module mpe_back import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  q_entry_t entry,
  output logic pop,
  input  logic [DT_W-1:0] time_step,
  input  logic [VALUE_W-1:0] initial_count,
  mpe_out_if.source out_ch
);

  back_state_t state, state_next;
  logic launched, launched_next;
  logic ovalid, ovalid_next;
  logic [VALUE_W-1:0] ocount, ocount_next;
  logic oclamped, oclamped_next;
  logic [VALUE_W-1:0] n, n_next;
  logic [VALUE_W-1:0] ga, ga_next;
  logic [VALUE_W-1:0] lo, lo_next;
  logic clamped, clamped_next;
  logic [RED_W-1:0] x, x_next;
  logic [SHIFT_W-1:0] k, k_next;
  logic [TERM_W-1:0] term, term_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [TERM_W-1:0] cval, cval_next;
  logic [VALUE_W-1:0] p1, p1_next;
  logic [VALUE_W-1:0] tv, tv_next;

  arith_req_t req;
  logic ar_done;
  logic [PROD_W-1:0] ar_result;
  logic [VALUE_W-1:0] prod_shr_sat;
  logic [VALUE_W-1:0] quot_sat;
  logic [VALUE_W-1:0] diff;
  logic [TERM_W-1:0] term_q;
  logic [SUM_W-1:0] sum_upd;

  mpe_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (ar_done),
    .result (ar_result)
  );

  // saturated views of the unit result
  assign prod_shr_sat = (|ar_result[PROD_W-1:VALUE_W+DT_W]) ? {VALUE_W{1'b1}}
                        : ar_result[VALUE_W+DT_W-1:DT_W];
  assign quot_sat = (|ar_result[PROD_W-1:VALUE_W]) ? {VALUE_W{1'b1}}
                    : ar_result[VALUE_W-1:0];
  assign diff = (ga >= lo) ? (ga - lo) : (lo - ga);
  assign term_q = ar_result[TERM_W-1:0];
  assign sum_upd = idx[0] ? (sum - SUM_W'(term_q)) : (sum + SUM_W'(term_q));

  assign out_ch.valid = ovalid;
  assign out_ch.count = ocount;
  assign out_ch.clamped = oclamped;

  // sequencer
  always_comb begin
    state_next = state;
    launched_next = launched;
    ovalid_next = ovalid;
    ocount_next = ocount;
    oclamped_next = oclamped;
    n_next = n;
    ga_next = ga;
    lo_next = lo;
    clamped_next = clamped;
    x_next = x;
    k_next = k;
    term_next = term;
    sum_next = sum;
    idx_next = idx;
    cval_next = cval;
    p1_next = p1;
    tv_next = tv;
    pop = 1'b0;
    req = '0;
    if (ovalid && out_ch.ready) ovalid_next = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (entry.kind)
            OP_ACC: begin
              ga_next = sat_add(ga, entry.amt_a);
              lo_next = sat_add(lo, entry.amt_b);
            end
            OP_SET: n_next = entry.amt_a;
            OP_REINIT: begin
              n_next = initial_count;
              ga_next = '0;
              lo_next = '0;
              clamped_next = 1'b0;
              state_next = B_EMIT;
            end
            OP_TICK: state_next = (n != '0 && lo != '0) ? B_MUL_BT : B_MUL_EU;
            default: ;
          endcase
        end
      end
      // loss times dt
      B_MUL_BT: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(lo);
          req.opb = VALUE_W'(time_step);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          state_next = B_DIV_X;
        end
      end
      // x = loss*dt/count
      B_DIV_X: begin
        if (!launched) begin
          req.start = 1'b1;
          req.is_div = 1'b1;
          req.opa = ar_result;
          req.opb = n;
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          if (ar_result >= PROD_W'(X_LIMIT)) begin
            cval_next = '0;
            state_next = B_MUL_P1;
          end else begin
            x_next = ar_result[RED_W-1:0];
            k_next = '0;
            state_next = B_RED;
          end
        end
      end
      // range reduction by ln 2
      B_RED: begin
        if (x >= LN2_Q32) begin
          x_next = x - LN2_Q32;
          k_next = k + SHIFT_W'(1);
        end else begin
          term_next = ONE_TERM;
          sum_next = ONE_SUM;
          idx_next = IDX_W'(1);
          state_next = B_T_MUL;
        end
      end
      // series term times r
      B_T_MUL: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(term);
          req.opb = VALUE_W'(x[DT_W-1:0]);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          term_next = ar_result[DT_W+TERM_W-1:DT_W];
          state_next = B_T_DIV;
        end
      end
      // series term divided by its index
      B_T_DIV: begin
        if (!launched) begin
          req.start = 1'b1;
          req.is_div = 1'b1;
          req.opa = PROD_W'(term);
          req.opb = VALUE_W'(idx);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          term_next = term_q;
          sum_next = sum_upd;
          if (idx == IDX_W'(TAYLOR_TERMS)) begin
            cval_next = TERM_W'(sum_upd >> k);
            state_next = B_MUL_P1;
          end else begin
            idx_next = idx + IDX_W'(1);
            state_next = B_T_MUL;
          end
        end
      end
      // count times C
      B_MUL_P1: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(n);
          req.opb = VALUE_W'(cval);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          p1_next = prod_shr_sat;
          state_next = B_MUL_T;
        end
      end
      // count times (1 - C)
      B_MUL_T: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(n);
          req.opb = VALUE_W'(ONE_TERM - cval);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          tv_next = ar_result[VALUE_W+DT_W-1:DT_W];
          state_next = B_MUL_AT;
        end
      end
      // gain times t
      B_MUL_AT: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(ga);
          req.opb = tv;
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          state_next = B_DIV_P2;
        end
      end
      // divided by loss, then the new count
      B_DIV_P2: begin
        if (!launched) begin
          req.start = 1'b1;
          req.is_div = 1'b1;
          req.opa = ar_result;
          req.opb = lo;
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          n_next = sat_add(p1, quot_sat);
          clamped_next = 1'b0;
          ga_next = '0;
          lo_next = '0;
          state_next = B_EMIT;
        end
      end
      // forward euler step
      B_MUL_EU: begin
        if (!launched) begin
          req.start = 1'b1;
          req.opa = PROD_W'(diff);
          req.opb = VALUE_W'(time_step);
          launched_next = 1'b1;
        end else if (ar_done) begin
          launched_next = 1'b0;
          clamped_next = 1'b0;
          if (ga >= lo) begin
            n_next = sat_add(n, prod_shr_sat);
          end else if (prod_shr_sat > n) begin
            n_next = '0;
            clamped_next = 1'b1;
          end else begin
            n_next = n - prod_shr_sat;
          end
          ga_next = '0;
          lo_next = '0;
          state_next = B_EMIT;
        end
      end
      // hand the count to the output register
      B_EMIT: begin
        if (!ovalid || out_ch.ready) begin
          ovalid_next = 1'b1;
          ocount_next = n;
          oclamped_next = clamped;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      launched <= 1'b0;
      ovalid <= 1'b0;
      n <= '0;
      ga <= '0;
      lo <= '0;
    end else begin
      state <= state_next;
      launched <= launched_next;
      ovalid <= ovalid_next;
      n <= n_next;
      ga <= ga_next;
      lo <= lo_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ocount <= ocount_next;
    oclamped <= oclamped_next;
    clamped <= clamped_next;
    x <= x_next;
    k <= k_next;
    term <= term_next;
    sum <= sum_next;
    idx <= idx_next;
    cval <= cval_next;
    p1 <= p1_next;
    tv <= tv_next;
  end

endmodule

// ----- sv/molecule_pool_exp_euler_step.sv -----
// Molecule pool with one exponential Euler step per tick, unsigned Q32.16 values and a
// Q0.32 time step. Items enter a 4-entry queue at one per cycle while it has room; the
// back end drains it. Add, increment, decrement and set count items are absorbed in the
// back end's idle state; reinit passes on through the emit state. A tick runs on one
// shared serial unit, by a single multiply when the forward Euler branch is taken. In
// the exponential branch it runs a multiply and a divide for x, range reduction by ln 2,
// the 14-term series of one multiply and one divide each, then three multiplies and a
// divide for the count; when exp(-x) underflows to zero the series is skipped. The
// result sits in an output register, so the queue keeps filling while it waits; a
// stalled output holds the back end in its emit state.
module molecule_pool_exp_euler_step import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  mpe_in_if.sink in_ch,
  mpe_out_if.source out_ch,
  input  logic cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0] cfg_data
);

  logic [DT_W-1:0] time_step;
  logic [VALUE_W-1:0] initial_count;
  logic push;
  logic full;
  logic pop;
  logic empty;
  q_entry_t push_entry;
  q_entry_t head_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
      initial_count <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP: time_step <= cfg_data[DT_W-1:0];
        REG_INITIAL_COUNT: initial_count <= cfg_data;
        default: ;
      endcase
    end
  end

  mpe_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  mpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .full      (full),
    .pop       (pop),
    .entry_out (head_entry),
    .empty     (empty)
  );

  mpe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .entry         (head_entry),
    .pop           (pop),
    .time_step     (time_step),
    .initial_count (initial_count),
    .out_ch        (out_ch)
  );

endmodule

// ----- sv/mpe_checker.sv -----
`include "molecule_pool_exp_euler_step_assert.svh"

module mpe_checker import mpe_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [VALUE_W-1:0] out_count,
  input logic out_clamped
);

  // a stalled result stays offered
  `MPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its value
  `MPE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_count) && $stable(out_clamped), "stalled result changed")

  // a clamped step always lands on zero
  `MPE_ASSERT_NOW(a_clamp_zero, out_valid && out_clamped, out_count == '0,
                  "clamped result is not zero")

  // nothing is offered right after reset
  `MPE_ASSERT_ALWAYS(a_reset_quiet, rst, !out_valid, "result offered after reset")

endmodule

bind molecule_pool_exp_euler_step mpe_checker u_mpe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_count   (out_ch.count),
  .out_clamped (out_ch.clamped)
);

// ----- tb/tb.sv -----
module tb import mpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LN2_FIX = 64'd2977044472;
  localparam logic [63:0] ONE_FIX = 64'd1 << 32;
  localparam logic [VALUE_W-1:0] VMAX = {VALUE_W{1'b1}};
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [VALUE_W-1:0] count;
    logic clamped;
  } pool_result_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0] cfg_data;

  mpe_in_if in_ch();
  mpe_out_if out_ch();

  molecule_pool_exp_euler_step DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted pool state and register copies
  logic [DT_W-1:0] dt_copy;
  logic [VALUE_W-1:0] init_copy;
  logic [VALUE_W-1:0] pool_count;
  logic [VALUE_W-1:0] gain_sum;
  logic [VALUE_W-1:0] loss_sum;

  pool_result_t pending_counts[$];
  int mismatches;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // saturating helpers at the block's widths
  function automatic logic [VALUE_W-1:0] add_sat(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_W] ? VMAX : s[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] clip48(logic [63:0] v);
    return (v > 64'(VMAX)) ? VMAX : v[VALUE_W-1:0];
  endfunction

  function automatic logic [63:0] quot_sat(logic [127:0] p, logic [63:0] d);
    if (d == 0 || p[127:64] >= d) return '1;
    return 64'(p / 128'(d));
  endfunction

  function automatic logic [63:0] scale_down(logic [127:0] p);
    if (p[127:96] != 0) return '1;
    return p[95:32];
  endfunction

  // exp(-x), x in Q.32, by range reduction and a 14-term series
  function automatic logic [63:0] decay_factor(logic [63:0] x);
    logic [63:0] k, r, s, term;
    k = x / LN2_FIX;
    r = x - k * LN2_FIX;
    if (k > 32) return 0;
    s = ONE_FIX;
    term = ONE_FIX;
    for (int i = 1; i <= 14; i++) begin
      term = ((term * r) >> 32) / i;
      if (i % 2 == 1) s = s - term;
      else s = s + term;
    end
    return s >> k;
  endfunction

  // one tick of the pool
  function automatic pool_result_t tick_pool();
    pool_result_t res;
    logic [63:0] n, x, c, t, p1, p2, delta;
    logic [VALUE_W-1:0] diff;
    n = 64'(pool_count);
    res.clamped = 1'b0;
    if (pool_count != 0 && loss_sum != 0) begin
      x = quot_sat(128'(loss_sum) * 128'(dt_copy), n);
      c = decay_factor(x);
      p1 = 64'(clip48(scale_down(128'(n) * 128'(c))));
      t = scale_down(128'(n) * 128'(ONE_FIX - c));
      p2 = 64'(clip48(quot_sat(128'(gain_sum) * 128'(t), 64'(loss_sum))));
      res.count = add_sat(p1[VALUE_W-1:0], p2[VALUE_W-1:0]);
    end else begin
      diff = (gain_sum >= loss_sum) ? gain_sum - loss_sum : loss_sum - gain_sum;
      delta = 64'(clip48(scale_down(128'(diff) * 128'(dt_copy))));
      if (gain_sum >= loss_sum) res.count = add_sat(pool_count, delta[VALUE_W-1:0]);
      else if (delta > n) begin
        res.count = '0;
        res.clamped = 1'b1;
      end else res.count = pool_count - delta[VALUE_W-1:0];
    end
    return res;
  endfunction

  // apply one accepted transaction to the predicted state
  task automatic predict_pool(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] g,
                              logic [VALUE_W-1:0] l, logic [VALUE_W-1:0] sa,
                              logic [VALUE_W-1:0] nc);
    logic [VALUE_W-1:0] mag;
    logic neg;
    pool_result_t res;
    neg = sa[VALUE_W-1];
    mag = neg ? -sa : sa;
    case (cmd)
      CMD_ADD: begin
        gain_sum = add_sat(gain_sum, g);
        loss_sum = add_sat(loss_sum, l);
      end
      CMD_INC: begin
        if (neg) loss_sum = add_sat(loss_sum, mag);
        else gain_sum = add_sat(gain_sum, mag);
      end
      CMD_DEC: begin
        if (neg) gain_sum = add_sat(gain_sum, mag);
        else loss_sum = add_sat(loss_sum, mag);
      end
      CMD_TICK: begin
        res = tick_pool();
        pool_count = res.count;
        gain_sum = '0;
        loss_sum = '0;
        pending_counts.push_back(res);
      end
      CMD_REINIT: begin
        pool_count = init_copy;
        gain_sum = '0;
        loss_sum = '0;
        res.count = init_copy;
        res.clamped = 1'b0;
        pending_counts.push_back(res);
      end
      CMD_SET: pool_count = nc;
      default: ;
    endcase
  endtask

  // send one transaction, predicting on acceptance
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] g = '0,
                           logic [VALUE_W-1:0] l = '0, logic [VALUE_W-1:0] sa = '0,
                           logic [VALUE_W-1:0] nc = '0);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.gain_amount <= g;
    in_ch.loss_amount <= l;
    in_ch.signed_amount <= sa;
    in_ch.new_count <= nc;
    do @(posedge clk); while (!in_ch.ready);
    predict_pool(cmd, g, l, sa, nc);
  endtask

  // drain all pending results, then let queued items settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [VALUE_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_TIME_STEP) dt_copy = data[DT_W-1:0];
    else init_copy = data;
    @(posedge clk);
  endtask

  // random 48-bit value spread over all magnitudes
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[VALUE_W-1:0] >> $urandom_range(VALUE_W - 1, 0);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_signed();
    logic [VALUE_W-1:0] v;
    v = rand_value();
    return $urandom_range(1) ? -v : v;
  endfunction

  // every command, the extremes and the special cases
  task automatic test_directed_ops();
    send_item(CMD_SET, '0, '0, '0, VMAX);
    send_item(CMD_ADD, VMAX, VMAX);
    send_item(CMD_ADD, VMAX, VMAX);
    send_item(CMD_TICK);
    send_item(CMD_INC);
    send_item(CMD_DEC);
    send_item(CMD_INC, '0, '0, {1'b1, {(VALUE_W - 1){1'b0}}});
    send_item(CMD_DEC, '0, '0, {1'b0, {(VALUE_W - 1){1'b1}}});
    send_item(CMD_DEC, '0, '0, -48'd12345);
    send_item(CMD_INC, '0, '0, 48'd777777);
    send_item(CMD_TICK);
    send_item(CMD_SET, '0, '0, '0, '0);
    send_item(CMD_ADD, '0, 48'h5_0000_0000);
    send_item(CMD_TICK);
    send_item(CMD_REINIT);
    send_item(3'd6, VMAX, VMAX, VMAX, VMAX);
    send_item(3'd7, VMAX, VMAX, VMAX, VMAX);
    send_item(CMD_SET, '0, '0, '0, 48'd1);
    send_item(CMD_ADD, VMAX, '0);
    send_item(CMD_TICK);
    send_item(CMD_SET, '0, '0, '0, VMAX);
    send_item(CMD_ADD, VMAX, 48'd1);
    send_item(CMD_TICK);
    quiesce();
  endtask

  // register extremes, including a zero time step
  task automatic test_config_extremes();
    write_reg(REG_TIME_STEP, '0);
    write_reg(REG_INITIAL_COUNT, VMAX);
    send_item(CMD_REINIT);
    send_item(CMD_ADD, 48'd300000, 48'd900000);
    send_item(CMD_TICK);
    send_item(CMD_ADD, 48'd5, 48'd9);
    send_item(CMD_SET, '0, '0, '0, '0);
    send_item(CMD_TICK);
    quiesce();
    write_reg(REG_TIME_STEP, 48'hFFFF_FFFF);
    write_reg(REG_INITIAL_COUNT, '0);
    send_item(CMD_REINIT);
    send_item(CMD_ADD, 48'd10, VMAX);
    send_item(CMD_TICK);
    quiesce();
  endtask

  // mostly accumulate-then-tick sequences with random content
  task automatic test_random_sequences(int n_items);
    int roll;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) send_item(CMD_ADD, rand_value(), rand_value());
      else if (roll < 55) send_item(CMD_INC, '0, '0, rand_signed());
      else if (roll < 70) send_item(CMD_DEC, '0, '0, rand_signed());
      else if (roll < 82) send_item(CMD_TICK);
      else if (roll < 86) send_item(CMD_REINIT);
      else if (roll < 94) send_item(CMD_SET, '0, '0, '0, rand_value());
      else if (roll < 97) send_item(3'($urandom_range(7, 6)), rand_value(), rand_value(),
                                    rand_signed(), rand_value());
      else send_item(CMD_ADD, $urandom_range(1) ? VMAX : '0, $urandom_range(1) ? VMAX : '0);
    end
    quiesce();
  endtask

  // idling phases with a fresh register setting each
  task automatic test_random_phases();
    int src_pct[4] = '{0, 47, 0, 37};
    int snk_pct[4] = '{0, 0, 47, 37};
    for (int p = 0; p < 4; p++) begin
      idle_pct = src_pct[p];
      stall_pct = snk_pct[p];
      case (p)
        0: write_reg(REG_TIME_STEP, 48'(TIME_STEP_RESET));
        1: write_reg(REG_TIME_STEP, 48'($urandom));
        2: write_reg(REG_TIME_STEP, 48'hFFFF_FFFF);
        default: write_reg(REG_TIME_STEP, 48'($urandom_range(65535)));
      endcase
      write_reg(REG_INITIAL_COUNT, rand_value());
      test_random_sequences(205);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count=%0h clamped=%0b", out_ch.count, out_ch.clamped);
      end else begin
        want = pending_counts.pop_front();
        if (out_ch.count !== want.count || out_ch.clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected count=%0h clamped=%0b, got count=%0h clamped=%0b",
                     want.count, want.clamped, out_ch.count, out_ch.clamped);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    dt_copy = TIME_STEP_RESET;
    init_copy = '0;
    pool_count = '0;
    gain_sum = '0;
    loss_sum = '0;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_TIME_STEP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.gain_amount = '0;
    in_ch.loss_amount = '0;
    in_ch.signed_amount = '0;
    in_ch.new_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_config_extremes();
    test_random_phases();

    if (pending_counts.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
